// File: hw/rtl/fbc_pkg.sv
// Shared types and constants of the frustum box cull test.
// Holds the stream payloads, the per-stage control struct and the register codes.
// No dependencies; fbc_transform, fbc_plane_cell and the top level import it.
`default_nettype none

package fbc_pkg;

   localparam int NUM_PLANES  = 6;
   localparam int FIELD_W     = 48;
   localparam int PLANE_W     = 64;
   localparam int TAG_W       = 16;
   localparam int CSR_INDEX_W = 3;

   // register indexes of the plane registers
   localparam logic [CSR_INDEX_W-1:0] PLANE_LEFT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] PLANE_RIGHT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] PLANE_BOTTOM = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] PLANE_TOP    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] PLANE_NEAR   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] PLANE_FAR    = 3'd5;

   localparam logic [CSR_INDEX_W-1:0] PLANE_CODE [NUM_PLANES] = '{
      PLANE_LEFT, PLANE_RIGHT, PLANE_BOTTOM, PLANE_TOP, PLANE_NEAR, PLANE_FAR
   };

   typedef struct packed {
      logic [FIELD_W-1:0] axis_x_column;
      logic [FIELD_W-1:0] axis_y_column;
      logic [FIELD_W-1:0] axis_z_column;
      logic [FIELD_W-1:0] translation;
      logic [FIELD_W-1:0] box_min;
      logic [FIELD_W-1:0] box_max;
      logic [TAG_W-1:0]   item_tag;
   } req_payload_type;

   typedef struct packed {
      logic             visible;
      logic [TAG_W-1:0] result_tag;
   } rsp_payload_type;

   // control that travels with a transaction through every stage
   typedef struct packed {
      logic             valid;
      logic             visible;
      logic [TAG_W-1:0] tag;
   } ctl_type;

   typedef struct packed {
      logic                   we;
      logic [CSR_INDEX_W-1:0] index;
      logic [PLANE_W-1:0]     data;
   } csr_type;

endpackage

`default_nettype wire

// File: hw/rtl/fbc_stream_if.sv
// Valid/ready stream interface used by the request and response channels.
// The payload type is set by the instantiating module (see fbc_pkg).
`default_nettype none

interface fbc_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/fbc_transform.sv
// Front end: unpacks a transaction, forms doubled center and doubled half extent and moves
// them into world space. Three registered stages. Depends on fbc_pkg.
`default_nettype none

module fbc_transform
   import fbc_pkg::*;
#(
   parameter int COORD_WIDTH = 16,
   parameter int FRAC_BITS   = 8,
   parameter int WC_W        = 36
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ctl_type                ctl_i,
   input  req_payload_type        item_i,
   output logic                   ready_o,
   output ctl_type                ctl_o,
   output logic signed [WC_W-1:0] wc_o [3],
   output logic signed [WC_W-1:0] wh_o [3],
   input  logic                   ready_i
);

   localparam int E     = COORD_WIDTH;
   localparam int PAD_W = 3 * E + FIELD_W;
   localparam int P_W   = 2 * E + 2;

   logic [PAD_W-1:0]   pad_col [3];
   logic [PAD_W-1:0]   pad_t;
   logic [PAD_W-1:0]   pad_min;
   logic [PAD_W-1:0]   pad_max;

   logic signed [E-1:0] col_in [3][3];
   logic signed [E:0]   abs_in [3][3];
   logic signed [E-1:0] t_in [3];
   logic signed [E-1:0] min_in [3];
   logic signed [E-1:0] max_in [3];
   logic signed [E:0]   c2_in [3];
   logic signed [E:0]   h2_in [3];

   logic signed [E-1:0] col_s1_ff [3][3];
   logic signed [E:0]   abs_s1_ff [3][3];
   logic signed [E-1:0] t_s1_ff [3];
   logic signed [E:0]   c2_s1_ff [3];
   logic signed [E:0]   h2_s1_ff [3];
   ctl_type             ctl_s1_ff;

   logic signed [P_W-1:0] pc_in [3][3];
   logic signed [P_W-1:0] ph_in [3][3];
   logic signed [P_W-1:0] pc_s2_ff [3][3];
   logic signed [P_W-1:0] ph_s2_ff [3][3];
   logic signed [E-1:0]   t_s2_ff [3];
   ctl_type               ctl_s2_ff;

   logic signed [WC_W-1:0] wc_in [3];
   logic signed [WC_W-1:0] wh_in [3];
   logic signed [WC_W-1:0] wc_s3_ff [3];
   logic signed [WC_W-1:0] wh_s3_ff [3];
   ctl_type                ctl_s3_ff;

   logic rdy_s1, rdy_s2, rdy_s3;

   // a stage takes a new transaction when it is empty or its content moves on
   assign rdy_s3  = !ctl_s3_ff.valid || ready_i;
   assign rdy_s2  = !ctl_s2_ff.valid || rdy_s3;
   assign rdy_s1  = !ctl_s1_ff.valid || rdy_s2;
   assign ready_o = rdy_s1;

   // unpack: bits beyond the field read as zero
   assign pad_col[0] = PAD_W'(item_i.axis_x_column);
   assign pad_col[1] = PAD_W'(item_i.axis_y_column);
   assign pad_col[2] = PAD_W'(item_i.axis_z_column);
   assign pad_t      = PAD_W'(item_i.translation);
   assign pad_min    = PAD_W'(item_i.box_min);
   assign pad_max    = PAD_W'(item_i.box_max);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int r = 0; r < 3; r++) begin
            col_in[k][r] = pad_col[k][r*E +: E];
            abs_in[k][r] = col_in[k][r][E-1] ? -((E+1)'(col_in[k][r]))
                                             : (E+1)'(col_in[k][r]);
         end
         t_in[k]   = pad_t[k*E +: E];
         min_in[k] = pad_min[k*E +: E];
         max_in[k] = pad_max[k*E +: E];
         c2_in[k]  = (E+1)'(max_in[k]) + (E+1)'(min_in[k]);
         h2_in[k]  = (E+1)'(max_in[k]) - (E+1)'(min_in[k]);
      end
   end

   // column k, row r contributes to world row r
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            pc_in[r][k] = P_W'(col_s1_ff[k][r]) * P_W'(c2_s1_ff[k]);
            ph_in[r][k] = P_W'(abs_s1_ff[k][r]) * P_W'(h2_s1_ff[k]);
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         wc_in[r] = (WC_W'(t_s2_ff[r]) <<< (FRAC_BITS + 1)) + WC_W'(pc_s2_ff[r][0])
                  + WC_W'(pc_s2_ff[r][1]) + WC_W'(pc_s2_ff[r][2]);
         wh_in[r] = WC_W'(ph_s2_ff[r][0]) + WC_W'(ph_s2_ff[r][1])
                  + WC_W'(ph_s2_ff[r][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_s1_ff <= '0;
         ctl_s2_ff <= '0;
         ctl_s3_ff <= '0;
      end else begin
         if (rdy_s1) ctl_s1_ff <= ctl_i;
         if (rdy_s2) ctl_s2_ff <= ctl_s1_ff;
         if (rdy_s3) ctl_s3_ff <= ctl_s2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_s1) begin
         col_s1_ff <= col_in;
         abs_s1_ff <= abs_in;
         t_s1_ff   <= t_in;
         c2_s1_ff  <= c2_in;
         h2_s1_ff  <= h2_in;
      end
      if (rdy_s2) begin
         pc_s2_ff <= pc_in;
         ph_s2_ff <= ph_in;
         t_s2_ff  <= t_s1_ff;
      end
      if (rdy_s3) begin
         wc_s3_ff <= wc_in;
         wh_s3_ff <= wh_in;
      end
   end

   assign ctl_o = ctl_s3_ff;
   assign wc_o  = wc_s3_ff;
   assign wh_o  = wh_s3_ff;

endmodule

`default_nettype wire

// File: hw/rtl/fbc_plane_cell.sv
// One cell of the plane chain: holds one plane register and tests the passing box
// against it in three registered stages, then hands the box on. Depends on fbc_pkg.
`default_nettype none

module fbc_plane_cell
   import fbc_pkg::*;
#(
   parameter int                     COORD_WIDTH = 16,
   parameter int                     FRAC_BITS   = 8,
   parameter int                     WC_W        = 36,
   parameter logic [CSR_INDEX_W-1:0] PLANE_ID    = PLANE_LEFT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  csr_type                csr_i,
   input  ctl_type                ctl_i,
   input  logic signed [WC_W-1:0] wc_i [3],
   input  logic signed [WC_W-1:0] wh_i [3],
   output logic                   ready_o,
   output ctl_type                ctl_o,
   output logic signed [WC_W-1:0] wc_o [3],
   output logic signed [WC_W-1:0] wh_o [3],
   input  logic                   ready_i
);

   localparam int N      = COORD_WIDTH;
   localparam int PAD_W  = 4 * N + PLANE_W;
   localparam int SPLIT  = (WC_W + 1) / 2;
   localparam int HI_W   = WC_W - SPLIT;
   localparam int PL_W   = SPLIT + N + 2;
   localparam int PH_W   = HI_W + N + 1;
   localparam int D_W    = N + 2 * FRAC_BITS + 1;
   localparam int LS_W   = ((PL_W > D_W) ? PL_W : D_W) + 3;
   localparam int HS_W   = PH_W + 3;
   localparam int TOT_W  = (((HS_W + SPLIT) > LS_W) ? (HS_W + SPLIT) : LS_W) + 1;

   logic [PLANE_W-1:0] plane_ff;
   logic [PAD_W-1:0]   pad_plane;
   logic signed [N-1:0] n_elem [3];
   logic signed [N:0]   n_abs [3];
   logic signed [N-1:0] d_elem;

   logic signed [SPLIT:0]  wc_lo [3];
   logic signed [SPLIT:0]  wh_lo [3];
   logic signed [HI_W-1:0] wc_hi [3];
   logic signed [HI_W-1:0] wh_hi [3];

   logic signed [PL_W-1:0] pcl_in [3];
   logic signed [PL_W-1:0] phl_in [3];
   logic signed [PH_W-1:0] pch_in [3];
   logic signed [PH_W-1:0] phh_in [3];
   logic signed [PL_W-1:0] pcl_a_ff [3];
   logic signed [PL_W-1:0] phl_a_ff [3];
   logic signed [PH_W-1:0] pch_a_ff [3];
   logic signed [PH_W-1:0] phh_a_ff [3];
   logic signed [WC_W-1:0] wc_a_ff [3];
   logic signed [WC_W-1:0] wh_a_ff [3];
   ctl_type                ctl_a_ff;

   logic signed [LS_W-1:0] lo_in;
   logic signed [HS_W-1:0] hi_in;
   logic signed [LS_W-1:0] lo_b_ff;
   logic signed [HS_W-1:0] hi_b_ff;
   logic signed [WC_W-1:0] wc_b_ff [3];
   logic signed [WC_W-1:0] wh_b_ff [3];
   ctl_type                ctl_b_ff;

   logic signed [TOT_W-1:0] tot_in;
   ctl_type                 ctl_c_in;
   logic signed [WC_W-1:0]  wc_c_ff [3];
   logic signed [WC_W-1:0]  wh_c_ff [3];
   ctl_type                 ctl_c_ff;

   logic rdy_a, rdy_b, rdy_c;

   assign rdy_c   = !ctl_c_ff.valid || ready_i;
   assign rdy_b   = !ctl_b_ff.valid || rdy_c;
   assign rdy_a   = !ctl_a_ff.valid || rdy_b;
   assign ready_o = rdy_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= '0;
      end else if (csr_i.we && (csr_i.index == PLANE_ID)) begin
         plane_ff <= csr_i.data;
      end
   end

   // plane elements a,b,c,d; bits beyond the register read as zero
   assign pad_plane = PAD_W'(plane_ff);
   assign d_elem    = pad_plane[3*N +: N];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         n_elem[r] = pad_plane[r*N +: N];
         n_abs[r]  = n_elem[r][N-1] ? -((N+1)'(n_elem[r])) : (N+1)'(n_elem[r]);
         // cut the wide operands into an unsigned low and a signed high part
         wc_lo[r]  = $signed({1'b0, wc_i[r][SPLIT-1:0]});
         wh_lo[r]  = $signed({1'b0, wh_i[r][SPLIT-1:0]});
         wc_hi[r]  = wc_i[r][WC_W-1:SPLIT];
         wh_hi[r]  = wh_i[r][WC_W-1:SPLIT];
         pcl_in[r] = PL_W'(wc_lo[r]) * PL_W'(n_elem[r]);
         phl_in[r] = PL_W'(wh_lo[r]) * PL_W'(n_abs[r]);
         pch_in[r] = PH_W'(wc_hi[r]) * PH_W'(n_elem[r]);
         phh_in[r] = PH_W'(wh_hi[r]) * PH_W'(n_abs[r]);
      end
   end

   always_comb begin
      lo_in = LS_W'(d_elem) <<< (2 * FRAC_BITS + 1);
      hi_in = '0;
      for (int r = 0; r < 3; r++) begin
         lo_in = lo_in + LS_W'(pcl_a_ff[r]) + LS_W'(phl_a_ff[r]);
         hi_in = hi_in + HS_W'(pch_a_ff[r]) + HS_W'(phh_a_ff[r]);
      end
   end

   // a negative total puts the box fully behind the plane: drop visibility
   always_comb begin
      tot_in           = (TOT_W'(hi_b_ff) <<< SPLIT) + TOT_W'(lo_b_ff);
      ctl_c_in         = ctl_b_ff;
      ctl_c_in.visible = ctl_b_ff.visible & ~tot_in[TOT_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
         ctl_c_ff <= '0;
      end else begin
         if (rdy_a) ctl_a_ff <= ctl_i;
         if (rdy_b) ctl_b_ff <= ctl_a_ff;
         if (rdy_c) ctl_c_ff <= ctl_c_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a) begin
         pcl_a_ff <= pcl_in;
         phl_a_ff <= phl_in;
         pch_a_ff <= pch_in;
         phh_a_ff <= phh_in;
         wc_a_ff  <= wc_i;
         wh_a_ff  <= wh_i;
      end
      if (rdy_b) begin
         lo_b_ff <= lo_in;
         hi_b_ff <= hi_in;
         wc_b_ff <= wc_a_ff;
         wh_b_ff <= wh_a_ff;
      end
      if (rdy_c) begin
         wc_c_ff <= wc_b_ff;
         wh_c_ff <= wh_b_ff;
      end
   end

   assign ctl_o = ctl_c_ff;
   assign wc_o  = wc_c_ff;
   assign wh_o  = wh_c_ff;

endmodule

`default_nettype wire

// File: hw/rtl/frustum_box_cull_test_core.sv
// Frustum box cull test, top level. One transaction per clock cycle sustained while the
// response stream is ready. Three stages of box transform, then a chain of six plane
// cells of three stages each (products, partial sums, final sum and sign). Every stage
// holds one transaction and moves it on whenever the next stage is free, so bubbles
// close up; while a result waits at the output, input is still taken as long as any
// stage is empty. The output is the last cell's final register. Plane registers reset
// to zero (every box visible); write them only while no transaction is in flight.
// Depends on fbc_pkg, fbc_stream_if, fbc_transform and fbc_plane_cell.
`default_nettype none

module frustum_box_cull_test_core
   import fbc_pkg::*;
#(
   parameter int COORD_WIDTH = 16,
   parameter int FRAC_BITS   = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   fbc_stream_if.sink             req_stream,
   fbc_stream_if.source           rsp_stream,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [PLANE_W-1:0]     csr_wdata
);

   localparam int P_W  = 2 * COORD_WIDTH + 2;
   localparam int T_W  = COORD_WIDTH + FRAC_BITS + 1;
   localparam int WC_W = ((P_W > T_W) ? P_W : T_W) + 2;

   csr_type                csr;
   ctl_type                head_ctl;
   ctl_type                chain_ctl [NUM_PLANES+1];
   logic signed [WC_W-1:0] wc_chain [NUM_PLANES+1][3];
   logic signed [WC_W-1:0] wh_chain [NUM_PLANES+1][3];
   logic                   chain_ready [NUM_PLANES+1];

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.data  = csr_wdata;

   assign head_ctl.valid   = req_stream.valid;
   assign head_ctl.visible = 1'b1;
   assign head_ctl.tag     = req_stream.payload.item_tag;

   fbc_transform #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS),
      .WC_W        (WC_W)
   ) u_transform (
      .clock   (clock),
      .reset   (reset),
      .ctl_i   (head_ctl),
      .item_i  (req_stream.payload),
      .ready_o (req_stream.ready),
      .ctl_o   (chain_ctl[0]),
      .wc_o    (wc_chain[0]),
      .wh_o    (wh_chain[0]),
      .ready_i (chain_ready[0])
   );

   for (genvar k = 0; k < NUM_PLANES; k++) begin : g_cell
      fbc_plane_cell #(
         .COORD_WIDTH (COORD_WIDTH),
         .FRAC_BITS   (FRAC_BITS),
         .WC_W        (WC_W),
         .PLANE_ID    (PLANE_CODE[k])
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .csr_i   (csr),
         .ctl_i   (chain_ctl[k]),
         .wc_i    (wc_chain[k]),
         .wh_i    (wh_chain[k]),
         .ready_o (chain_ready[k]),
         .ctl_o   (chain_ctl[k+1]),
         .wc_o    (wc_chain[k+1]),
         .wh_o    (wh_chain[k+1]),
         .ready_i (chain_ready[k+1])
      );
   end

   assign chain_ready[NUM_PLANES]     = rsp_stream.ready;
   assign rsp_stream.valid              = chain_ctl[NUM_PLANES].valid;
   assign rsp_stream.payload.visible    = chain_ctl[NUM_PLANES].visible;
   assign rsp_stream.payload.result_tag = chain_ctl[NUM_PLANES].tag;

`ifndef SYNTHESIS
   // the pipeline comes out of reset empty
   assert property (@(posedge clock) $past(reset) |-> !rsp_stream.valid)
      else $error("result valid right after reset");

   // input can only block when every stage is full behind a stalled result
   assert property (@(posedge clock) disable iff (reset)
      !req_stream.ready |-> rsp_stream.valid && !rsp_stream.ready)
      else $error("input blocked without a stalled result");

   // a blocked front end means the first plane cell is blocked as well
   assert property (@(posedge clock) disable iff (reset)
      !req_stream.ready |-> !chain_ready[0])
      else $error("front end blocked while plane chain has room");
`endif

endmodule

`default_nettype wire
